>>> rtl/y4m_pkg.sv
// shared types, constants and character tables of the y4m stream deframer
package y4m_pkg;

    localparam int DIM_BITS    = 16;
    localparam int OFFSET_BITS = 48;
    localparam int SIZE_BITS   = 33;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_FRAME  = 3'd1;
    localparam logic [2:0] KIND_PIXEL  = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic [3:0] ERR_HDR_NO_NL    = 4'd0;
    localparam logic [3:0] ERR_MAGIC        = 4'd1;
    localparam logic [3:0] ERR_WIDTH        = 4'd2;
    localparam logic [3:0] ERR_HEIGHT       = 4'd3;
    localparam logic [3:0] ERR_RATE         = 4'd4;
    localparam logic [3:0] ERR_CHROMA       = 4'd5;
    localparam logic [3:0] ERR_MISSING_TAG  = 4'd6;
    localparam logic [3:0] ERR_MARK_NO_NL   = 4'd7;
    localparam logic [3:0] ERR_BAD_MARKER   = 4'd8;
    localparam logic [3:0] ERR_TRUNCATED    = 4'd9;
    localparam logic [3:0] ERR_NONE         = 4'd15;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOS  = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_C     = 8'h43;

    localparam logic [3:0] MAGIC_LEN  = 4'd9;
    localparam logic [3:0] MARKER_LEN = 4'd5;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]             item_kind;
        logic [DIM_BITS-1:0]    frame_width;
        logic [DIM_BITS-1:0]    frame_height;
        logic [31:0]            rate_numerator;
        logic [31:0]            rate_denominator;
        logic [SIZE_BITS-1:0]   frame_byte_count;
        logic [7:0]             pixel_value;
        logic [SIZE_BITS-1:0]   byte_in_frame;
        logic                   last_of_frame;
        logic [3:0]             error_code;
        logic [OFFSET_BITS-1:0] stream_position;
    } out_item_t;

    function automatic logic [7:0] magic_char(input logic [3:0] idx);
        case (idx)
            4'd0:    magic_char = "Y";
            4'd1:    magic_char = "U";
            4'd2:    magic_char = "V";
            4'd3:    magic_char = "4";
            4'd4:    magic_char = "M";
            4'd5:    magic_char = "P";
            4'd6:    magic_char = "E";
            4'd7:    magic_char = "G";
            4'd8:    magic_char = "2";
            default: magic_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] marker_char(input logic [3:0] idx);
        case (idx)
            4'd0:    marker_char = "F";
            4'd1:    marker_char = "R";
            4'd2:    marker_char = "A";
            4'd3:    marker_char = "M";
            4'd4:    marker_char = "E";
            default: marker_char = 8'h00;
        endcase
    endfunction

    // chroma candidates: 0 = 420, 1 = 420jpeg, 2 = 420mpeg2
    function automatic logic [7:0] chroma_char(input logic [1:0] cand, input logic [3:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            4'd0:    ch = "4";
            4'd1:    ch = "2";
            4'd2:    ch = "0";
            4'd3:    ch = (cand == 2'd1) ? "j" : "m";
            4'd4:    ch = "p";
            4'd5:    ch = "e";
            4'd6:    ch = "g";
            4'd7:    ch = "2";
            default: ch = 8'h00;
        endcase
        chroma_char = ch;
    endfunction

    function automatic logic [3:0] chroma_len(input logic [1:0] cand);
        case (cand)
            2'd0:    chroma_len = 4'd3;
            2'd1:    chroma_len = 4'd7;
            default: chroma_len = 4'd8;
        endcase
    endfunction

endpackage

>>> rtl/y4m_in_if.sv
// input item channel of the y4m stream deframer
interface y4m_in_if import y4m_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/y4m_out_if.sv
// result item channel of the y4m stream deframer
interface y4m_out_if import y4m_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/y4m_stream_deframer.sv
// y4m stream deframer: header parser, frame marker matcher and payload pass-through
// Takes a YUV4MPEG2 byte stream one item per clock (a byte or an end-of-stream
// mark) and gives at most one result item per input item: header parsed, frame
// start, pixel byte, clean end or error. Each item is handled in the cycle it is
// accepted and its result sits in an output register, so a byte can be taken on
// every clock while the sink keeps up. The one exception is the end of the header
// line: the I420 frame size (W*H + 2*ceil(W/2)*ceil(H/2)) comes from a two-stage
// multiply pipeline, so after W or H changes the header result is held back until
// the sum stage holds the new size. Errors are sticky; after a clean end or an
// error the block takes items and gives nothing until reset.
module y4m_stream_deframer import y4m_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    y4m_in_if.sink          stream,
    y4m_out_if.source       result
);

    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_TAGS    = 3'd1;
    localparam logic [2:0] PH_MARKER  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_DEAD    = 3'd5;

    // parser state
    logic [2:0]             phase_reg, phase_next;
    logic [3:0]             tok_reg, tok_next;
    logic [7:0]             letter_reg, letter_next;
    logic [2:0]             cmatch_reg, cmatch_next;
    logic [32:0]            acc_reg, acc_next;
    logic                   seen_reg, seen_next;
    logic                   bad_reg, bad_next;
    logic                   rpart_reg, rpart_next;
    logic [DIM_BITS-1:0]    width_reg, width_next;
    logic [DIM_BITS-1:0]    height_reg, height_next;
    logic [31:0]            num_reg, num_next;
    logic [31:0]            den_reg, den_next;
    logic [3:0]             tags_reg, tags_next;
    logic [3:0]             lerr_reg, lerr_next;
    logic [SIZE_BITS-1:0]   pcnt_reg, pcnt_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [1:0]             settle_reg, settle_next;

    // frame size pipeline
    logic [2*DIM_BITS-1:0]  prod_wh_reg;
    logic [2*DIM_BITS-1:0]  prod_c_reg;
    logic [SIZE_BITS-1:0]   size_reg;
    logic [DIM_BITS-1:0]    half_w;
    logic [DIM_BITS-1:0]    half_h;

    // result register
    logic                   ovalid_reg, ovalid_next;
    logic [2:0]             okind_reg, okind_next;
    logic [7:0]             opix_reg, opix_next;
    logic [SIZE_BITS-1:0]   oidx_reg, oidx_next;
    logic                   olast_reg, olast_next;
    logic [3:0]             oerr_reg, oerr_next;
    logic [OFFSET_BITS-1:0] opos_reg, opos_next;

    logic                   settled;
    logic                   accept;
    logic [7:0]             c;
    logic                   is_digit;
    logic [36:0]            acc_mul;

    // decimal step on the current byte
    logic [32:0]            dc_acc;
    logic                   dc_seen;
    logic                   dc_bad;

    // tag finish computed from the current token
    logic                   fin_ok;
    logic [3:0]             fin_err;
    logic [3:0]             fin_tags;
    logic [DIM_BITS-1:0]    fin_w;
    logic [DIM_BITS-1:0]    fin_h;
    logic [31:0]            fin_den;
    logic                   dec_dim_ok;
    logic                   dec_u32_ok;
    logic [3:0]             tok_inc;
    logic [3:0]             tok_m1;
    logic                   c_ok;
    logic [3:0]             hdr_err;

    assign settled  = (settle_reg == 2'd0);
    assign stream.ready = !ovalid_reg || (result.ready && settled);
    assign accept   = stream.valid && stream.ready;
    assign c        = stream.data.data_byte;
    assign is_digit = (c >= "0") && (c <= "9");
    assign tok_inc  = (tok_reg < 4'd15) ? tok_reg + 4'd1 : tok_reg;
    assign tok_m1   = tok_reg - 4'd1;

    // acc * 10 + digit as shift-add, saturating at 2^32
    assign acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {29'd0, c - 8'h30};

    always_comb
    begin
        dc_acc  = acc_reg;
        dc_seen = seen_reg;
        dc_bad  = bad_reg;
        if (is_digit)
        begin
            dc_seen = 1'b1;
            if (!acc_reg[32])
            begin
                dc_acc = (acc_mul[36:32] != 5'd0) ? {1'b1, 32'd0} : acc_mul[32:0];
            end
        end
        else
        begin
            dc_bad = 1'b1;
        end
    end

    assign dec_dim_ok = seen_reg && !bad_reg && (acc_reg[32:DIM_BITS] == '0);
    assign dec_u32_ok = seen_reg && !bad_reg && !acc_reg[32];

    always_comb
    begin
        c_ok = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (cmatch_reg[i] && (tok_m1 == chroma_len(2'(i))))
            begin
                c_ok = 1'b1;
            end
        end
    end

    // what closing the current tag would do
    always_comb
    begin
        fin_ok   = 1'b1;
        fin_tags = tags_reg;
        fin_w    = width_reg;
        fin_h    = height_reg;
        fin_den  = den_reg;
        fin_err  = ERR_NONE;
        if (tok_reg != 4'd0)
        begin
            case (letter_reg)
                CH_W:
                begin
                    fin_ok = dec_dim_ok;
                    fin_err = ERR_WIDTH;
                    if (dec_dim_ok)
                    begin
                        fin_w = acc_reg[DIM_BITS-1:0];
                        fin_tags[0] = 1'b1;
                    end
                end
                CH_H:
                begin
                    fin_ok = dec_dim_ok;
                    fin_err = ERR_HEIGHT;
                    if (dec_dim_ok)
                    begin
                        fin_h = acc_reg[DIM_BITS-1:0];
                        fin_tags[1] = 1'b1;
                    end
                end
                CH_F:
                begin
                    fin_ok = rpart_reg && dec_u32_ok;
                    fin_err = ERR_RATE;
                    if (fin_ok)
                    begin
                        fin_den = acc_reg[31:0];
                        fin_tags[2] = 1'b1;
                    end
                end
                CH_C:
                begin
                    fin_ok = c_ok;
                    fin_err = ERR_CHROMA;
                    if (c_ok)
                    begin
                        fin_tags[3] = 1'b1;
                    end
                end
                default:
                begin
                    fin_ok = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        tok_next    = tok_reg;
        letter_next = letter_reg;
        cmatch_next = cmatch_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        bad_next    = bad_reg;
        rpart_next  = rpart_reg;
        width_next  = width_reg;
        height_next = height_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        tags_next   = tags_reg;
        lerr_next   = lerr_reg;
        pcnt_next   = pcnt_reg;
        offset_next = offset_reg;
        hdr_err     = lerr_reg;

        ovalid_next = ovalid_reg && !(result.ready && settled);
        okind_next  = okind_reg;
        opix_next   = opix_reg;
        oidx_next   = oidx_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        opos_next   = opos_reg;

        if (accept && (phase_reg != PH_DONE) && (phase_reg != PH_DEAD))
        begin
            // common result defaults
            opix_next  = 8'd0;
            oidx_next  = '0;
            olast_next = 1'b0;
            oerr_next  = 4'd0;
            opos_next  = '0;
            if (stream.data.req_type == REQ_EOS)
            begin
                ovalid_next = 1'b1;
                okind_next  = KIND_ERROR;
                phase_next  = PH_DEAD;
                case (phase_reg)
                    PH_MAGIC, PH_TAGS: oerr_next = ERR_HDR_NO_NL;
                    PH_MARKER:
                    begin
                        if (tok_reg == 4'd0)
                        begin
                            okind_next = KIND_END;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            oerr_next = ERR_MARK_NO_NL;
                        end
                    end
                    default: oerr_next = ERR_TRUNCATED;
                endcase
            end
            else
            begin
                offset_next = offset_reg + OFFSET_BITS'(1);
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if ((c == CH_SPACE) || (c == CH_NL))
                        begin
                            if ((bad_reg || (tok_reg != MAGIC_LEN)) && (lerr_reg == ERR_NONE))
                            begin
                                hdr_err = ERR_MAGIC;
                            end
                            lerr_next = hdr_err;
                            tok_next  = 4'd0;
                            bad_next  = 1'b0;
                            phase_next = PH_TAGS;
                        end
                        else
                        begin
                            if ((tok_reg >= MAGIC_LEN) || (magic_char(tok_reg) != c))
                            begin
                                bad_next = 1'b1;
                            end
                            tok_next = tok_inc;
                        end
                    end
                    PH_TAGS:
                    begin
                        if ((c == CH_SPACE) || (c == CH_NL))
                        begin
                            width_next  = fin_w;
                            height_next = fin_h;
                            den_next    = fin_den;
                            tags_next   = fin_tags;
                            tok_next    = 4'd0;
                            if (!fin_ok && (lerr_reg == ERR_NONE))
                            begin
                                hdr_err = fin_err;
                            end
                            lerr_next = hdr_err;
                        end
                        else if (tok_reg == 4'd0)
                        begin
                            letter_next = c;
                            acc_next    = '0;
                            seen_next   = 1'b0;
                            bad_next    = 1'b0;
                            rpart_next  = 1'b0;
                            cmatch_next = 3'b111;
                            tok_next    = 4'd1;
                        end
                        else
                        begin
                            tok_next = tok_inc;
                            case (letter_reg)
                                CH_W, CH_H:
                                begin
                                    acc_next  = dc_acc;
                                    seen_next = dc_seen;
                                    bad_next  = dc_bad;
                                end
                                CH_F:
                                begin
                                    if ((c == CH_COLON) && !rpart_reg)
                                    begin
                                        if (dec_u32_ok)
                                        begin
                                            num_next = acc_reg[31:0];
                                        end
                                        else
                                        begin
                                            bad_next = 1'b1;
                                        end
                                        rpart_next = 1'b1;
                                        acc_next   = '0;
                                        seen_next  = 1'b0;
                                    end
                                    else
                                    begin
                                        acc_next  = dc_acc;
                                        seen_next = dc_seen;
                                        bad_next  = dc_bad;
                                    end
                                end
                                CH_C:
                                begin
                                    for (int i = 0; i < 3; i++)
                                    begin
                                        if ((tok_m1 >= chroma_len(2'(i)))
                                            || (chroma_char(2'(i), tok_m1) != c))
                                        begin
                                            cmatch_next[i] = 1'b0;
                                        end
                                    end
                                end
                                default:
                                begin
                                    tok_next = tok_inc;
                                end
                            endcase
                        end
                    end
                    PH_MARKER:
                    begin
                        if (c == CH_NL)
                        begin
                            ovalid_next = 1'b1;
                            if (bad_reg || (tok_reg < MARKER_LEN))
                            begin
                                okind_next = KIND_ERROR;
                                oerr_next  = ERR_BAD_MARKER;
                                phase_next = PH_DEAD;
                            end
                            else
                            begin
                                okind_next = KIND_FRAME;
                                opos_next  = offset_next;
                                pcnt_next  = '0;
                                tok_next   = 4'd0;
                                bad_next   = 1'b0;
                                phase_next = (size_reg != '0) ? PH_PAYLOAD : PH_MARKER;
                            end
                        end
                        else
                        begin
                            if ((tok_reg < MARKER_LEN) && (marker_char(tok_reg) != c))
                            begin
                                bad_next = 1'b1;
                            end
                            tok_next = tok_inc;
                        end
                    end
                    default:
                    begin
                        // payload byte pass-through
                        ovalid_next = 1'b1;
                        okind_next  = KIND_PIXEL;
                        opix_next   = c;
                        oidx_next   = pcnt_reg;
                        pcnt_next   = pcnt_reg + SIZE_BITS'(1);
                        if (pcnt_next == size_reg)
                        begin
                            olast_next = 1'b1;
                            tok_next   = 4'd0;
                            bad_next   = 1'b0;
                            phase_next = PH_MARKER;
                        end
                    end
                endcase

                // end of header line
                if ((c == CH_NL) && ((phase_reg == PH_MAGIC) || (phase_reg == PH_TAGS)))
                begin
                    ovalid_next = 1'b1;
                    if ((hdr_err == ERR_NONE) && (tags_next != 4'hf))
                    begin
                        hdr_err = ERR_MISSING_TAG;
                    end
                    lerr_next = hdr_err;
                    if (hdr_err != ERR_NONE)
                    begin
                        okind_next = KIND_ERROR;
                        oerr_next  = hdr_err;
                        phase_next = PH_DEAD;
                    end
                    else
                    begin
                        okind_next = KIND_HEADER;
                        opos_next  = offset_next;
                        tok_next   = 4'd0;
                        bad_next   = 1'b0;
                        phase_next = PH_MARKER;
                    end
                end
            end
        end

        // hold results until the frame size pipeline catches up with W and H
        if ((width_next != width_reg) || (height_next != height_reg))
        begin
            settle_next = 2'd2;
        end
        else if (!settled)
        begin
            settle_next = settle_reg - 2'd1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    assign half_w = DIM_BITS'(({1'b0, width_reg} + (DIM_BITS+1)'(1)) >> 1);
    assign half_h = DIM_BITS'(({1'b0, height_reg} + (DIM_BITS+1)'(1)) >> 1);

    // two-stage frame size: products, then sum
    always_ff @(posedge clk)
    begin
        prod_wh_reg <= (2*DIM_BITS)'(width_reg) * (2*DIM_BITS)'(height_reg);
        prod_c_reg  <= (2*DIM_BITS)'(half_w) * (2*DIM_BITS)'(half_h);
        size_reg    <= {1'b0, prod_wh_reg} + {prod_c_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            tok_reg    <= 4'd0;
            letter_reg <= 8'd0;
            cmatch_reg <= 3'b111;
            acc_reg    <= '0;
            seen_reg   <= 1'b0;
            bad_reg    <= 1'b0;
            rpart_reg  <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
            num_reg    <= '0;
            den_reg    <= '0;
            tags_reg   <= 4'd0;
            lerr_reg   <= ERR_NONE;
            pcnt_reg   <= '0;
            offset_reg <= '0;
            settle_reg <= 2'd2;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            tok_reg    <= tok_next;
            letter_reg <= letter_next;
            cmatch_reg <= cmatch_next;
            acc_reg    <= acc_next;
            seen_reg   <= seen_next;
            bad_reg    <= bad_next;
            rpart_reg  <= rpart_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            num_reg    <= num_next;
            den_reg    <= den_next;
            tags_reg   <= tags_next;
            lerr_reg   <= lerr_next;
            pcnt_reg   <= pcnt_next;
            offset_reg <= offset_next;
            settle_reg <= settle_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        okind_reg <= okind_next;
        opix_reg  <= opix_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
        opos_reg  <= opos_next;
    end

    // stream parameters do not change while a result is pending
    assign result.valid                 = ovalid_reg && settled;
    assign result.data.item_kind        = okind_reg;
    assign result.data.frame_width      = width_reg;
    assign result.data.frame_height     = height_reg;
    assign result.data.rate_numerator   = num_reg;
    assign result.data.rate_denominator = den_reg;
    assign result.data.frame_byte_count = size_reg;
    assign result.data.pixel_value      = opix_reg;
    assign result.data.byte_in_frame    = oidx_reg;
    assign result.data.last_of_frame    = olast_reg;
    assign result.data.error_code       = oerr_reg;
    assign result.data.stream_position  = opos_reg;

endmodule

>>> tb/sv/tb_y4m_stream_deframer.sv
// self-checking testbench of the y4m stream deframer
`timescale 1ns / 1ps

module tb_y4m_stream_deframer;
    import y4m_pkg::*;

    // parser phases of the local predictor
    typedef enum logic [2:0] {
        P_MAGIC, P_TAGS, P_MARKER, P_PAYLOAD, P_DONE, P_DEAD
    } parse_phase_t;

    // one row of the directed table; want_kind is checked only where typed is set
    typedef struct {
        logic       req;
        logic [7:0] ch;
        bit         typed;
        logic [2:0] want_kind;
    } stim_row_t;

    localparam int  TARGET_ITEMS = 1800;
    localparam int  CYCLE_LIMIT  = 600000;
    localparam int  HOLD_OFF     = 300;
    localparam int  TAIL_CYCLES  = 12;
    localparam int  FRAME_W      = 5;
    localparam int  FRAME_H      = 3;

    logic clk;
    logic rst_n;

    y4m_in_if  stream ();
    y4m_out_if result ();

    y4m_stream_deframer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream.sink),
        .result (result.source)
    );

    // clock and run limit
    initial clk = 1'b0;
    always #5 clk = ~clk;

    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned sent_items;
    int unsigned got_results;
    int unsigned frames_seen;
    int unsigned pixels_seen;
    bit          hold_done;
    bit          stim_done;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("y4m_stream_deframer verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // predictor: mirrors the deframer state at the block's widths
    // ---------------------------------------------------------------
    parse_phase_t      ph;
    int unsigned       tok_idx;
    logic [7:0]        tag_ch;
    logic [2:0]        chroma_alive;
    logic [63:0]       dec_acc;
    bit                dec_any;
    logic [15:0]       width_q;
    logic [15:0]       height_q;
    logic [31:0]       rate_num_q;
    logic [31:0]       rate_den_q;
    logic [3:0]        tags_seen;
    logic [3:0]        first_err;
    logic [63:0]       pix_idx;
    logic [47:0]       offset_q;
    bit                tok_bad;
    bit                after_colon;

    string magic_word  = "YUV4MPEG2";
    string marker_word = "FRAME";
    string chroma_name [3] = '{"420", "420jpeg", "420mpeg2"};

    out_item_t expected_results [$];

    function automatic logic [63:0] i420_size();
        logic [63:0] w;
        logic [63:0] h;
        w = width_q;
        h = height_q;
        return w * h + 64'd2 * ((w + 1) >> 1) * ((h + 1) >> 1);
    endfunction

    function automatic out_item_t base_result(logic [2:0] kind);
        out_item_t r;
        logic [63:0] sz;
        sz = i420_size();
        r = '0;
        r.item_kind        = kind;
        r.frame_width      = width_q;
        r.frame_height     = height_q;
        r.rate_numerator   = rate_num_q;
        r.rate_denominator = rate_den_q;
        r.frame_byte_count = sz[SIZE_BITS-1:0];
        return r;
    endfunction

    function automatic void keep_first_error(logic [3:0] code);
        if (first_err == ERR_NONE)
            first_err = code;
    endfunction

    function automatic bit number_fits(logic [63:0] maxv);
        return dec_any && !tok_bad && dec_acc <= maxv;
    endfunction

    function automatic void clear_number();
        dec_acc = '0;
        dec_any = 0;
    endfunction

    // digits saturate once past 32 bits
    function automatic void take_digit(logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            dec_any = 1;
            if (dec_acc <= 64'hFFFF_FFFF)
            begin
                dec_acc = dec_acc * 10 + 64'(c - "0");
                if (dec_acc > 64'hFFFF_FFFF)
                    dec_acc = 64'h1_0000_0000;
            end
        end
        else
            tok_bad = 1;
    endfunction

    function automatic void tag_byte(logic [7:0] c);
        int unsigned p;
        if (tok_idx == 0)
        begin
            tag_ch = c;
            clear_number();
            tok_bad = 0;
            after_colon = 0;
            chroma_alive = 3'b111;
            tok_idx = 1;
            return;
        end
        p = tok_idx - 1;
        if (tok_idx < 15)
            tok_idx++;
        if (tag_ch == CH_W || tag_ch == CH_H)
            take_digit(c);
        else if (tag_ch == CH_F)
        begin
            if (c == CH_COLON && !after_colon)
            begin
                if (number_fits(64'hFFFF_FFFF))
                    rate_num_q = dec_acc[31:0];
                else
                    tok_bad = 1;
                after_colon = 1;
                clear_number();
            end
            else
                take_digit(c);
        end
        else if (tag_ch == CH_C)
        begin
            for (int i = 0; i < 3; i++)
                if (p >= chroma_name[i].len() || chroma_name[i][p] != c)
                    chroma_alive[i] = 1'b0;
        end
    endfunction

    function automatic void close_tag();
        bit ok;
        ok = 0;
        if (tok_idx == 0)
            return;
        case (tag_ch)
            CH_W:
                if (number_fits(64'hFFFF)) begin width_q = dec_acc[15:0]; tags_seen[0] = 1; end
                else keep_first_error(ERR_WIDTH);
            CH_H:
                if (number_fits(64'hFFFF)) begin height_q = dec_acc[15:0]; tags_seen[1] = 1; end
                else keep_first_error(ERR_HEIGHT);
            CH_F:
                if (after_colon && number_fits(64'hFFFF_FFFF))
                begin
                    rate_den_q = dec_acc[31:0];
                    tags_seen[2] = 1;
                end
                else keep_first_error(ERR_RATE);
            CH_C:
            begin
                for (int i = 0; i < 3; i++)
                    if (chroma_alive[i] && tok_idx - 1 == chroma_name[i].len())
                        ok = 1;
                if (ok) tags_seen[3] = 1;
                else keep_first_error(ERR_CHROMA);
            end
            default: ;
        endcase
        tok_idx = 0;
    endfunction

    function automatic out_item_t fail_result(logic [3:0] code);
        out_item_t r;
        r = base_result(KIND_ERROR);
        r.error_code = code;
        ph = P_DEAD;
        return r;
    endfunction

    function automatic void open_marker();
        ph = P_MARKER;
        tok_idx = 0;
        tok_bad = 0;
    endfunction

    function automatic out_item_t header_done();
        out_item_t r;
        close_tag();
        if (first_err == ERR_NONE && tags_seen != 4'hF)
            keep_first_error(ERR_MISSING_TAG);
        if (first_err != ERR_NONE)
            return fail_result(first_err);
        r = base_result(KIND_HEADER);
        r.stream_position = offset_q;
        open_marker();
        return r;
    endfunction

    function automatic void reset_parser();
        ph = P_MAGIC;
        tok_idx = 0;
        tag_ch = '0;
        chroma_alive = 3'b111;
        clear_number();
        width_q = '0;
        height_q = '0;
        rate_num_q = '0;
        rate_den_q = '0;
        tags_seen = '0;
        first_err = ERR_NONE;
        pix_idx = '0;
        offset_q = '0;
        tok_bad = 0;
        after_colon = 0;
    endfunction

    // advances the parser by one accepted item; returns 1 with a result if any
    function automatic bit parse_item(logic req, logic [7:0] c, output out_item_t r);
        logic [63:0] sz;
        r = '0;
        if (ph == P_DONE || ph == P_DEAD)
            return 0;
        if (req == REQ_EOS)
        begin
            case (ph)
                P_MAGIC, P_TAGS: r = fail_result(ERR_HDR_NO_NL);
                P_MARKER:
                    if (tok_idx == 0)
                    begin
                        r = base_result(KIND_END);
                        ph = P_DONE;
                    end
                    else
                        r = fail_result(ERR_MARK_NO_NL);
                default: r = fail_result(ERR_TRUNCATED);
            endcase
            return 1;
        end
        offset_q = offset_q + 1;
        case (ph)
            P_MAGIC:
            begin
                if (c == CH_SPACE || c == CH_NL)
                begin
                    if (tok_bad || tok_idx != 9)
                        keep_first_error(ERR_MAGIC);
                    tok_idx = 0;
                    tok_bad = 0;
                    if (c == CH_NL)
                    begin
                        r = header_done();
                        return 1;
                    end
                    ph = P_TAGS;
                    return 0;
                end
                if (tok_idx >= 9 || magic_word[tok_idx] != c)
                    tok_bad = 1;
                if (tok_idx < 15)
                    tok_idx++;
                return 0;
            end
            P_TAGS:
            begin
                if (c == CH_NL)
                begin
                    r = header_done();
                    return 1;
                end
                if (c == CH_SPACE)
                    close_tag();
                else
                    tag_byte(c);
                return 0;
            end
            P_MARKER:
            begin
                if (c == CH_NL)
                begin
                    if (tok_bad || tok_idx < 5)
                    begin
                        r = fail_result(ERR_BAD_MARKER);
                        return 1;
                    end
                    r = base_result(KIND_FRAME);
                    r.stream_position = offset_q;
                    pix_idx = '0;
                    if (i420_size() != 0)
                        ph = P_PAYLOAD;
                    else
                        open_marker();
                    return 1;
                end
                if (tok_idx < 5 && marker_word[tok_idx] != c)
                    tok_bad = 1;
                if (tok_idx < 15)
                    tok_idx++;
                return 0;
            end
            default:
            begin
                sz = i420_size();
                r = base_result(KIND_PIXEL);
                r.pixel_value = c;
                r.byte_in_frame = pix_idx[SIZE_BITS-1:0];
                pix_idx++;
                if (pix_idx >= sz)
                begin
                    r.last_of_frame = 1'b1;
                    open_marker();
                end
                return 1;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap(bit busy_phase);
        int unsigned r;
        if (busy_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    bit src_burst;
    bit dir_typed;
    logic [2:0] dir_kind;

    // entered and left at a falling edge
    task automatic offer(logic req, logic [7:0] c);
        int unsigned gap;
        out_item_t   r;
        bit          has_r;
        gap = pick_gap(src_burst);
        repeat (gap)
        begin
            stream.valid <= 1'b0;
            stream.data  <= '{req_type: 1'($urandom_range(0, 1)),
                              data_byte: 8'($urandom_range(0, 255))};
            @(negedge clk);
        end
        stream.valid <= 1'b1;
        stream.data  <= '{req_type: req, data_byte: c};
        @(posedge clk);
        while (!stream.ready)
            @(posedge clk);
        has_r = parse_item(req, c, r);
        if (dir_typed && (!has_r || r.item_kind != dir_kind))
        begin
            $error("directed row: kind expected %0d, predictor gives %0d (has %0d)",
                   dir_kind, r.item_kind, has_r);
            fail_count++;
        end
        if (has_r)
            expected_results.push_back(r);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic offer_text(string s);
        for (int i = 0; i < s.len(); i++)
            offer(REQ_DATA, s[i]);
    endtask

    // random byte that is not a newline
    function automatic logic [7:0] any_but_nl();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_NL)
            b = 8'hFF;
        return b;
    endfunction

    task automatic offer_marker();
        int unsigned extra;
        offer_text("FRAME");
        extra = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 6);
        repeat (extra)
            offer(REQ_DATA, any_but_nl());
        offer(REQ_DATA, CH_NL);
    endtask

    stim_row_t dir_rows [$];

    // typed kind only on the newline that closes a line
    function automatic void add_line(string s, logic [2:0] kind);
        for (int i = 0; i < s.len(); i++)
            dir_rows.push_back('{REQ_DATA, s[i], (i == s.len() - 1), kind});
    endfunction

    initial
    begin
        int unsigned size;
        int unsigned ending;
        int unsigned cut;
        cycle_count = 0;
        fail_count = 0;
        sent_items = 0;
        stim_done = 0;
        src_burst = 0;
        dir_typed = 0;
        dir_kind = KIND_HEADER;
        reset_parser();
        stream.valid = 1'b0;
        stream.data = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: doubled spaces, unknown tag, repeated width tag, marker with trailer
        add_line("YUV4MPEG2  W9 Xq H3 F25:1 C420 W5\n", KIND_HEADER);
        add_line("FRAME Ip\n", KIND_FRAME);
        foreach (dir_rows[i])
        begin
            dir_typed = dir_rows[i].typed;
            dir_kind  = dir_rows[i].want_kind;
            offer(dir_rows[i].req, dir_rows[i].ch);
        end
        dir_typed = 0;

        // random: well-formed frames with random content, then a random ending
        size = FRAME_W * FRAME_H + 2 * ((FRAME_W + 1) / 2) * ((FRAME_H + 1) / 2);
        for (int i = 0; i < size; i++)
            offer(REQ_DATA, 8'($urandom_range(0, 255)));
        while (sent_items < TARGET_ITEMS)
        begin
            src_burst = ($urandom_range(0, 3) == 0);
            offer_marker();
            for (int i = 0; i < size; i++)
                offer(REQ_DATA, 8'($urandom_range(0, 255)));
        end
        src_burst = 0;
        ending = $urandom_range(0, 3);
        case (ending)
            0: offer(REQ_EOS, 8'($urandom_range(0, 255)));
            1:
            begin
                offer_text("FR");
                offer(REQ_EOS, 8'h00);
            end
            2: offer_text("FRA\n");
            default:
            begin
                offer_marker();
                cut = $urandom_range(1, size - 1);
                repeat (cut)
                    offer(REQ_DATA, 8'($urandom_range(0, 255)));
                offer(REQ_EOS, 8'h00);
            end
        endcase
        // the block must stay silent from here on
        repeat (8)
            offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        stream.valid <= 1'b0;
        stim_done = 1;
    end

    // ---------------------------------------------------------------
    // receiver side: random stalls plus one long hold-off
    // ---------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        int unsigned held;
        result.ready = 1'b0;
        hold_done = 0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && pixels_seen > 200)
            begin
                // long hold-off while the sender keeps offering
                result.ready <= 1'b0;
                held++;
                if (held >= HOLD_OFF)
                    hold_done = 1;
            end
            else if (stall > 0)
            begin
                result.ready <= 1'b0;
                stall--;
            end
            else
            begin
                result.ready <= 1'b1;
                stall = pick_gap(($urandom_range(0, 4) == 0));
            end
        end
    end

    // compare accepted results with the oldest expectation
    task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && result.valid && result.ready)
        begin
            got = result.data;
            got_results++;
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected, kind %0d", got.item_kind);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.item_kind == KIND_FRAME) frames_seen++;
                if (got.item_kind == KIND_PIXEL) pixels_seen++;
                cmp_field("item_kind", want.item_kind, got.item_kind);
                cmp_field("frame_width", want.frame_width, got.frame_width);
                cmp_field("frame_height", want.frame_height, got.frame_height);
                cmp_field("rate_numerator", want.rate_numerator, got.rate_numerator);
                cmp_field("rate_denominator", want.rate_denominator, got.rate_denominator);
                cmp_field("frame_byte_count", want.frame_byte_count, got.frame_byte_count);
                cmp_field("pixel_value", want.pixel_value, got.pixel_value);
                cmp_field("byte_in_frame", want.byte_in_frame, got.byte_in_frame);
                cmp_field("last_of_frame", want.last_of_frame, got.last_of_frame);
                cmp_field("error_code", want.error_code, got.error_code);
                cmp_field("stream_position", want.stream_position, got.stream_position);
            end
        end
    end

    // end of run: drain, let the header pipeline settle, then report
    initial
    begin
        got_results = 0;
        frames_seen = 0;
        pixels_seen = 0;
        wait (stim_done);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("sent %0d stream items, checked %0d results (%0d frames, %0d pixel bytes)",
                 sent_items, got_results, frames_seen, pixels_seen);
        $display("stream ended in state %0d, long output hold-off done: %0d", ph, hold_done);
        if (fail_count == 0)
            $display("y4m_stream_deframer verification clean");
        else
            $display("y4m_stream_deframer verification failed");
        $finish;
    end

endmodule
